// ===== sv/rrbs_pkg.sv =====
// Shared types, widths and codes for the four-way round-robin burst scheduler.
`timescale 1ns / 1ps

package rrbs_pkg;

  // Queue geometry.
  localparam int NUM_DIRS    = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = (NUM_DIRS * QUEUE_DEPTH > 1) ?
                               $clog2(NUM_DIRS * QUEUE_DEPTH) : 1;

  // Field widths.
  localparam int DIR_W   = 2;
  localparam int TAG_W   = 32;
  localparam int TIME_W  = 16;
  localparam int MAX_W   = 8;
  localparam int ENTRY_W = TAG_W + TIME_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef logic [DIR_W-1:0]  dir_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [MAX_W-1:0]  served_t;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_TURN    = 2'd1;

  // Register reset values.
  localparam dir_t    START_DIRECTION_RST = 2'd0;
  localparam served_t MAX_PER_TURN_RST    = 8'd4;
  localparam served_t SERVED_SAT          = 8'hFF;

  // Request codes.
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_NEXT    = 1'b1;

  // One input item.
  typedef struct packed {
    logic              req_type;
    logic [TAG_W-1:0]  car_tag;
    dir_t              car_direction;
    logic [TIME_W-1:0] hold_time;
  } req_t;

  // One result item.
  typedef struct packed {
    logic              grant_valid;
    logic [TAG_W-1:0]  granted_tag;
    logic [TIME_W-1:0] granted_time;
    dir_t              granted_direction;
    logic              direction_changed;
    logic              enqueue_rejected;
  } rsp_t;

endpackage

// ===== sv/rrbs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module rrbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rrbs_rotate.sv =====
// Picks the next non-empty direction clockwise from the current one.
`timescale 1ns / 1ps

module rrbs_rotate import rrbs_pkg::*; (
  input  dir_t                cur_dir,
  input  logic [NUM_DIRS-1:0] nonempty,
  output dir_t                next_dir
);

  // Search from the farthest step down so that the nearest non-empty queue
  // clockwise of the current one wins; the current direction comes last.
  always_comb begin
    dir_t cand;
    next_dir = cur_dir;
    for (int k = NUM_DIRS; k >= 1; k--) begin
      cand = cur_dir + DIR_W'(k);
      if (nonempty[cand]) begin
        next_dir = cand;
      end
    end
  end

endmodule

// ===== sv/four_way_round_robin_burst_scheduler_core.sv =====
// Top level of the four-way round-robin burst scheduler.
`timescale 1ns / 1ps

// Usage:
// - Input channel: an item (in_data) transfers at a rising edge with start
//   high and busy low. busy is high only while a configuration write is
//   offered, so items and register writes never land in the same cycle.
// - An enqueue item appends a car to its direction's queue, or reports
//   enqueue_rejected when that queue is full. A next item grants the head
//   car of the current direction, rotating clockwise past empty queues when
//   the current queue is empty or the turn's burst limit is used up.
// - Result channel: every item produces exactly one result, shown on
//   out_data for one cycle with out_valid high, once the item has passed
//   the input register and the result stage. The receiver cannot stall.
// - Throughput: one item per cycle while busy is low. Stage one updates
//   queue state and addresses the car store; the result stage registers the store's read data.
// - Configuration: cfg_index/cfg_data transfer when cfg_valid and cfg_ready
//   are high; cfg_ready is always high. Writing start_direction reloads the
//   current direction and restarts the turn. Unknown indexes are ignored.
// - Reset (synchronous, active low) empties all queues, serves north first,
//   sets the burst limit to four and drops any item in flight. The car
//   store needs no clearing since only written entries are ever read.

module four_way_round_robin_burst_scheduler_core import rrbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  in_data,
  output logic                  out_valid,
  output rsp_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Input register stage.
  logic s1_valid_r;
  req_t s1_req_r;

  // Scheduler state.
  ptr_t    head_r [NUM_DIRS];
  ptr_t    head_nxt [NUM_DIRS];
  ptr_t    tail_r [NUM_DIRS];
  ptr_t    tail_nxt [NUM_DIRS];
  cnt_t    cnt_r [NUM_DIRS];
  cnt_t    cnt_nxt [NUM_DIRS];
  dir_t    cur_dir_r, cur_dir_nxt;
  served_t served_r, served_nxt;
  dir_t    prev_dir_r, prev_dir_nxt;
  logic    granted_before_r, granted_before_nxt;
  served_t max_per_turn_r;

  // Result stage.
  logic s2_valid_r;
  logic s2_grant_r;
  dir_t s2_dir_r;
  logic s2_changed_r;
  logic s2_rejected_r;

  // Stage-one control.
  logic                item_accept;
  logic                cfg_write;
  logic [NUM_DIRS-1:0] nonempty;
  logic                any_car;
  logic                need_rotate;
  dir_t                rot_dir;
  dir_t                grant_dir;
  logic                do_grant;
  logic                do_enqueue;
  logic                enq_full;
  served_t             served_base;
  addr_t               waddr;
  addr_t               raddr;
  logic [ENTRY_W-1:0]  rdata;

  assign busy        = cfg_valid;
  assign cfg_ready   = 1'b1;
  assign item_accept = start && !busy;
  assign cfg_write   = cfg_valid && cfg_ready;

  // Per-direction occupancy.
  always_comb begin
    for (int i = 0; i < NUM_DIRS; i++) begin
      nonempty[i] = (cnt_r[i] != '0);
    end
  end
  assign any_car = |nonempty;

  rrbs_rotate u_rotate (
    .cur_dir  (cur_dir_r),
    .nonempty (nonempty),
    .next_dir (rot_dir)
  );

  // Decide what the registered item does this cycle.
  assign need_rotate = !nonempty[cur_dir_r] || (served_r >= max_per_turn_r);
  assign grant_dir   = need_rotate ? rot_dir : cur_dir_r;
  assign do_grant    = s1_valid_r && (s1_req_r.req_type == REQ_NEXT) && any_car;
  assign enq_full    = (cnt_r[s1_req_r.car_direction] == CNT_W'(QUEUE_DEPTH));
  assign do_enqueue  = s1_valid_r && (s1_req_r.req_type == REQ_ENQUEUE) && !enq_full;
  assign served_base = need_rotate ? '0 : served_r;

  // Car store addresses: one row of QUEUE_DEPTH entries per direction.
  assign waddr = addr_t'(s1_req_r.car_direction) * addr_t'(QUEUE_DEPTH)
               + addr_t'(tail_r[s1_req_r.car_direction]);
  assign raddr = addr_t'(grant_dir) * addr_t'(QUEUE_DEPTH)
               + addr_t'(head_r[grant_dir]);

  rrbs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_DIRS * QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_enqueue),
    .waddr (waddr),
    .wdata ({s1_req_r.car_tag, s1_req_r.hold_time}),
    .re    (do_grant),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Next-state logic for queues, turn and history.
  always_comb begin
    head_nxt           = head_r;
    tail_nxt           = tail_r;
    cnt_nxt            = cnt_r;
    cur_dir_nxt        = cur_dir_r;
    served_nxt         = served_r;
    prev_dir_nxt       = prev_dir_r;
    granted_before_nxt = granted_before_r;

    if (do_enqueue) begin
      tail_nxt[s1_req_r.car_direction] =
        (tail_r[s1_req_r.car_direction] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
        tail_r[s1_req_r.car_direction] + PTR_W'(1);
      cnt_nxt[s1_req_r.car_direction] = cnt_r[s1_req_r.car_direction] + CNT_W'(1);
    end

    if (do_grant) begin
      head_nxt[grant_dir] = (head_r[grant_dir] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                            head_r[grant_dir] + PTR_W'(1);
      cnt_nxt[grant_dir]  = cnt_r[grant_dir] - CNT_W'(1);
      cur_dir_nxt         = grant_dir;
      served_nxt          = (served_base == SERVED_SAT) ? served_base :
                            served_base + MAX_W'(1);
      prev_dir_nxt        = grant_dir;
      granted_before_nxt  = 1'b1;
    end

    // A start_direction write restarts the turn.
    if (cfg_write && (cfg_index == CFG_START_DIRECTION)) begin
      cur_dir_nxt = cfg_data[DIR_W-1:0];
      served_nxt  = '0;
    end
  end

  // Input register and scheduler state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      cur_dir_r        <= START_DIRECTION_RST;
      served_r         <= '0;
      prev_dir_r       <= '0;
      granted_before_r <= 1'b0;
      max_per_turn_r   <= MAX_PER_TURN_RST;
      for (int i = 0; i < NUM_DIRS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      s1_valid_r       <= item_accept;
      cur_dir_r        <= cur_dir_nxt;
      served_r         <= served_nxt;
      prev_dir_r       <= prev_dir_nxt;
      granted_before_r <= granted_before_nxt;
      head_r           <= head_nxt;
      tail_r           <= tail_nxt;
      cnt_r            <= cnt_nxt;
      if (cfg_write && (cfg_index == CFG_MAX_PER_TURN)) begin
        max_per_turn_r <= cfg_data[MAX_W-1:0];
      end
    end
  end

  // Input payload.
  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_req_r <= in_data;
    end
  end

  // Result stage strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // Result stage payload.
  always_ff @(posedge clk) begin
    s2_grant_r    <= do_grant;
    s2_dir_r      <= grant_dir;
    s2_changed_r  <= !granted_before_r || (prev_dir_r != grant_dir);
    s2_rejected_r <= s1_valid_r && (s1_req_r.req_type == REQ_ENQUEUE) && enq_full;
  end

  // Result fields; grant fields read as zero when nothing was granted.
  assign out_valid                  = s2_valid_r;
  assign out_data.grant_valid       = s2_grant_r;
  assign out_data.granted_tag       = s2_grant_r ? rdata[ENTRY_W-1:TIME_W] : '0;
  assign out_data.granted_time      = s2_grant_r ? rdata[TIME_W-1:0] : '0;
  assign out_data.granted_direction = s2_grant_r ? s2_dir_r : '0;
  assign out_data.direction_changed = s2_grant_r && s2_changed_r;
  assign out_data.enqueue_rejected  = s2_rejected_r;

  // Every item in the input register yields a result from the result stage.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> out_valid)
    else $error("item in flight produced no result");

  // A grant always takes a car from a non-empty queue.
  a_grant_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_grant |-> (cnt_r[grant_dir] != '0))
    else $error("grant from an empty queue");

  // Queue occupancy never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CNT_W'(QUEUE_DEPTH)) && (cnt_r[1] <= CNT_W'(QUEUE_DEPTH)) &&
    (cnt_r[2] <= CNT_W'(QUEUE_DEPTH)) && (cnt_r[3] <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count above depth");

  // A result never reports both a grant and a rejected enqueue.
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.grant_valid && out_data.enqueue_rejected))
    else $error("result mixes grant and rejection");

endmodule
